// File: hdl/iil_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iil_pkg: shared types for the indexed insert list
// Request and status codes, the cell command and the controller states.
// ----------------------------------------------------------------------------
package iil_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned REQ_W   = 3;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_AT   = 3'd2,
        REQ_REM_HEAD = 3'd3,
        REQ_REM_TAIL = 3'd4,
        REQ_DUMP     = 3'd5
    } req_code_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_POS   = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DOWN,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage
`default_nettype wire

// File: hdl/iil_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iil_req_if: request channel of the indexed insert list
// Valid/ready channel carrying the request type, value and position.
// ----------------------------------------------------------------------------
interface iil_req_if;
    import iil_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/iil_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iil_rsp_if: result channel of the indexed insert list
// Valid/ready channel carrying status, dumped item, count and last marker.
// ----------------------------------------------------------------------------
interface iil_rsp_if;
    import iil_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] item_out;
    logic [COUNT_W-1:0]       count;
    logic                     last;

    modport source (output valid, output status, output item_out, output count,
                    output last, input ready);
    modport sink   (input valid, input status, input item_out, input count,
                    input last, output ready);
endinterface
`default_nettype wire

// File: hdl/iil_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iil_cell: one storage cell of the list chain
// Holds one element and takes data from its neighbors on a broadcast command.
// ----------------------------------------------------------------------------
module iil_cell
    import iil_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned IDX_W = 5
)
(
    input  wire logic                     clk,
    input  wire cell_cmd_t                cmd,
    input  wire logic [IDX_W-1:0]         pos,
    input  wire logic [IDX_W-1:0]         tail,
    input  wire logic signed [DATA_W-1:0] lower_data,
    input  wire logic signed [DATA_W-1:0] upper_data,
    input  wire logic signed [DATA_W-1:0] head_data,
    output logic signed [DATA_W-1:0]      data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (MY_IDX == pos)
                    data_next = cmd.value;
                else if (MY_IDX > pos)
                    data_next = lower_data;
            end
            CELL_SHIFT_DOWN:
                data_next = upper_data;
            CELL_ROTATE:
            begin
                // The head wraps around to the tail so a full pass restores the list.
                if (MY_IDX == tail)
                    data_next = head_data;
                else if (MY_IDX < tail)
                    data_next = upper_data;
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// File: hdl/indexed_insert_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_insert_list: bounded ordered list built as a chain of cells
// Requests insert at head, tail or a position, remove head or tail, or dump.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req, results leave on rsp; both are valid/ready.
//   Every edit (insert or remove) gives one result with status and the new
//   count, in the cycle after the request beat. Unused request codes give none.
//   All cells shift in parallel, so a new request is taken every cycle while
//   results are drained.
//   A dump gives one result per element, head first, one per cycle while rsp
//   is not stalled; the chain rotates one place per result, and the block
//   takes no new request until the dump is over. An empty dump gives a single
//   empty-status result.
//   Results sit in an output register; a request is taken when that register
//   is empty or being drained in the same cycle. When rsp stalls, the result
//   holds and no new request is taken until it leaves.
//   Reset empties the list and clears the output valid flag; no clearing pass
//   is needed because cell contents beyond the count are never read.
// ----------------------------------------------------------------------------
module indexed_insert_list
    import iil_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    iil_req_if.sink    req,
    iil_rsp_if.source  rsp
);

    localparam int unsigned IDX_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam logic [IDX_W-1:0] CAP_VAL = IDX_W'(CAPACITY);
    localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0] remain_reg, remain_next;

    logic                     out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]        out_status_reg, out_status_next;
    logic signed [DATA_W-1:0] out_item_reg, out_item_next;
    logic [COUNT_W-1:0]       out_count_reg, out_count_next;
    logic                     out_last_reg, out_last_next;

    cell_cmd_t                cmd;
    logic [IDX_W-1:0]         ins_pos;
    logic [IDX_W-1:0]         tail;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         occ_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic                     out_free;
    logic                     accept;
    logic                     load_out;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign tail      = occ_reg - ONE;
    assign occ_ext   = CMP_W'(occ_reg);

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_item_next   = out_item_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        load_out        = 1'b0;
        cmd.op          = CELL_HOLD;
        cmd.value       = req.value;
        ins_pos         = '0;
        pos_ext         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT:
                        begin
                            if (req.req_type == REQ_INS_HEAD)
                                pos_ext = '0;
                            else if (req.req_type == REQ_INS_TAIL)
                                pos_ext = occ_ext;
                            else
                                pos_ext = CMP_W'(req.position);
                            ins_pos  = pos_ext[IDX_W-1:0];
                            load_out = 1'b1;
                            out_item_next = '0;
                            out_last_next = 1'b1;
                            if (pos_ext > occ_ext)
                                out_status_next = STAT_POS;
                            else if (occ_reg == CAP_VAL)
                                out_status_next = STAT_FULL;
                            else
                            begin
                                out_status_next = STAT_OK;
                                cmd.op   = CELL_INSERT;
                                occ_next = occ_reg + ONE;
                            end
                        end
                        REQ_REM_HEAD, REQ_REM_TAIL:
                        begin
                            load_out = 1'b1;
                            out_item_next = '0;
                            out_last_next = 1'b1;
                            if (occ_reg == '0)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                out_status_next = STAT_OK;
                                occ_next = occ_reg - ONE;
                                if (req.req_type == REQ_REM_HEAD)
                                    cmd.op = CELL_SHIFT_DOWN;
                            end
                        end
                        REQ_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                load_out        = 1'b1;
                                out_item_next   = '0;
                                out_last_next   = 1'b1;
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                remain_next = occ_reg;
                                state_next  = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    load_out        = 1'b1;
                    out_status_next = STAT_OK;
                    out_item_next   = cell_data[0];
                    out_last_next   = (remain_reg == ONE);
                    cmd.op          = CELL_ROTATE;
                    remain_next     = remain_reg - ONE;
                    if (remain_reg == ONE)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // Count reports the element total after the request, modulo the field width.
        cnt_ext = CMP_W'(occ_next);
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_count_next = cnt_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_item_reg   <= out_item_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] lower_d;
        logic signed [DATA_W-1:0] upper_d;

        if (g == 0)
        begin : g_first
            assign lower_d = '0;
        end
        else
        begin : g_lower
            assign lower_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_top
            assign upper_d = '0;
        end
        else
        begin : g_upper
            assign upper_d = cell_data[g+1];
        end

        iil_cell #(
            .IDX   (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (ins_pos),
            .tail       (tail),
            .lower_data (lower_d),
            .upper_data (upper_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[g])
        );
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.item_out = out_item_reg;
    assign rsp.count    = out_count_reg;
    assign rsp.last     = out_last_reg;

endmodule
`default_nettype wire

// File: tb/sv/indexed_insert_list_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_insert_list_tb: self-checking bench for the indexed insert list
// Directed edge cases, then random request mixes that swing the list between
// empty and full. A shadow list predicts every result beat, and a monitor
// compares each beat field by field. Sender bursts and receiver stalls vary.
// ----------------------------------------------------------------------------
module indexed_insert_list_tb;
    import iil_pkg::*;

    localparam int unsigned CAPACITY    = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam int unsigned RAND_ITEMS  = 128;

    // Request codes that the block ignores.
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

    typedef struct {
        logic [REQ_W-1:0]         kind;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
    } req_beat_t;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] item;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } rsp_beat_t;

    logic clk;
    logic rst_n;

    iil_req_if req_ch ();
    iil_rsp_if rsp_ch ();

    indexed_insert_list #(.CAPACITY(CAPACITY)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    req_beat_t                pending_req_q[$];
    rsp_beat_t                expected_rsp_q[$];
    logic signed [DATA_W-1:0] shadow_list[$];

    int unsigned gen_count;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned phase_cnt;
    int unsigned cycle_cnt;
    int unsigned err_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow list and result prediction
    // ------------------------------------------------------------------
    function automatic void add_expected(status_t st, logic signed [DATA_W-1:0] item,
                                         logic last);
        rsp_beat_t b;
        b.status = st;
        b.item   = item;
        b.count  = COUNT_W'(shadow_list.size());
        b.last   = last;
        expected_rsp_q.push_back(b);
    endfunction

    function automatic status_t shadow_insert(int unsigned pos,
                                              logic signed [DATA_W-1:0] val);
        // The position check comes before the full check.
        if (pos > shadow_list.size())
            return STAT_POS;
        if (shadow_list.size() >= CAPACITY)
            return STAT_FULL;
        shadow_list.insert(pos, val);
        return STAT_OK;
    endfunction

    function automatic void predict_list_results(req_beat_t b);
        status_t st;
        case (b.kind)
            REQ_INS_HEAD: add_expected(shadow_insert(0, b.value), '0, 1'b1);
            REQ_INS_TAIL: add_expected(shadow_insert(shadow_list.size(), b.value), '0, 1'b1);
            REQ_INS_AT:   add_expected(shadow_insert(b.pos, b.value), '0, 1'b1);
            REQ_REM_HEAD, REQ_REM_TAIL:
            begin
                if (shadow_list.size() == 0)
                    st = STAT_EMPTY;
                else
                begin
                    if (b.kind == REQ_REM_HEAD)
                        void'(shadow_list.pop_front());
                    else
                        void'(shadow_list.pop_back());
                    st = STAT_OK;
                end
                add_expected(st, '0, 1'b1);
            end
            REQ_DUMP:
            begin
                if (shadow_list.size() == 0)
                    add_expected(STAT_EMPTY, '0, 1'b1);
                else
                    foreach (shadow_list[i])
                        add_expected(STAT_OK, shadow_list[i], i == shadow_list.size() - 1);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers; gen_count follows the list size as items are queued
    // so that positions and the request mix can be steered.
    // ------------------------------------------------------------------
    function automatic void queue_request(logic [REQ_W-1:0] kind,
                                          logic signed [DATA_W-1:0] val,
                                          logic [POS_W-1:0] pos);
        req_beat_t b;
        b.kind  = kind;
        b.value = val;
        b.pos   = pos;
        pending_req_q.push_back(b);
        case (kind)
            REQ_INS_HEAD, REQ_INS_TAIL:
                if (gen_count < CAPACITY) gen_count++;
            REQ_INS_AT:
                if (pos <= gen_count && gen_count < CAPACITY) gen_count++;
            REQ_REM_HEAD, REQ_REM_TAIL:
                if (gen_count > 0) gen_count--;
            default: ;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0:       return MAX_VAL;
            1:       return MIN_VAL;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_position();
        case ($urandom_range(0, 9))
            8:       return POS_W'($urandom_range(gen_count, CAPACITY));
            9:       return POS_W'($urandom_range(0, 31));
            default: return POS_W'($urandom_range(0, gen_count));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length with random gaps.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_req
        req_beat_t nxt;
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= '0;
            req_ch.value    <= '0;
            req_ch.position <= '0;
            burst_left      <= 0;
            gap_left        <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                nxt.kind  = req_ch.req_type;
                nxt.value = req_ch.value;
                nxt.pos   = req_ch.position;
                predict_list_results(nxt);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_req_q.size() > 0)
                begin
                    nxt = pending_req_q.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= nxt.kind;
                    req_ch.value    <= nxt.value;
                    req_ch.position <= nxt.pos;
                    if (burst_left <= 1)
                    begin
                        // Now and then a long burst with no gaps at all.
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left <= $urandom_range(20, 40);
                            gap_left   <= 0;
                        end
                        else
                        begin
                            burst_left <= $urandom_range(1, 6);
                            gap_left   <= $urandom_range(0, 5);
                        end
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: the stall style is redrawn at random on a phase_cnt period.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            stall_mode   <= 0;
            phase_cnt    <= 0;
        end
        else
        begin
            phase_cnt <= phase_cnt + 1;
            if (phase_cnt % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= (phase_cnt % 5) != 0;
                    default:
                        if ($urandom_range(0, 15) == 0)
                        begin
                            stall_left   <= $urandom_range(4, 12);
                            rsp_ch.ready <= 1'b0;
                        end
                        else
                            rsp_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_rsp
        rsp_beat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual status %0d item %0d",
                         $time, rsp_ch.status, rsp_ch.item_out);
                err_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                    err_count++;
                end
                if (rsp_ch.item_out !== want.item)
                begin
                    $display("%0t: item_out mismatch: expected %0d actual %0d",
                             $time, want.item, rsp_ch.item_out);
                    err_count++;
                end
                if (rsp_ch.count !== want.count)
                begin
                    $display("%0t: count mismatch: expected %0d actual %0d",
                             $time, want.count, rsp_ch.count);
                    err_count++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %0d actual %0d",
                             $time, want.last, rsp_ch.last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_rsp_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : main
        int unsigned n_items;
        int unsigned roll;
        bit          grow;

        rst_n     = 1'b0;
        gen_count = 0;

        // Empty list: dump, both removals and an insert past the end.
        queue_request(REQ_DUMP, rand_value(), 5'd0);
        queue_request(REQ_REM_HEAD, rand_value(), 5'd0);
        queue_request(REQ_REM_TAIL, rand_value(), 5'd31);
        queue_request(REQ_INS_AT, MAX_VAL, 5'd1);
        // Removing the only element leaves the list empty.
        queue_request(REQ_INS_AT, MAX_VAL, 5'd0);
        queue_request(REQ_REM_TAIL, '0, 5'd0);
        queue_request(REQ_INS_HEAD, -1, 5'd0);
        queue_request(REQ_REM_HEAD, '0, 5'd0);
        queue_request(REQ_DUMP, '0, 5'd0);
        // Insert at the position equal to the size appends at the tail.
        queue_request(REQ_INS_TAIL, MIN_VAL, 5'd0);
        queue_request(REQ_INS_HEAD, MAX_VAL, 5'd0);
        queue_request(REQ_INS_AT, '0, 5'd2);
        queue_request(REQ_INS_AT, 32'sh5555_5555, 5'd1);
        queue_request(REQ_SPARE_6, rand_value(), 5'd31);
        queue_request(REQ_SPARE_7, rand_value(), 5'd0);
        queue_request(REQ_DUMP, '0, 5'd0);
        while (gen_count < CAPACITY)
            queue_request(REQ_INS_TAIL, rand_value(), 5'($urandom_range(0, 31)));
        // A full list: full status, and the position error wins over full.
        queue_request(REQ_INS_HEAD, rand_value(), 5'd0);
        queue_request(REQ_INS_AT, rand_value(), 5'd31);
        queue_request(REQ_INS_AT, rand_value(), 5'd16);
        queue_request(REQ_DUMP, '0, 5'd0);

        grow    = 1'b0;
        n_items = 0;
        while (n_items < RAND_ITEMS)
        begin
            if (gen_count == 0)
                grow = 1'b1;
            else if (gen_count == CAPACITY && $urandom_range(0, 1) == 0)
                grow = 1'b0;
            else if ($urandom_range(0, 19) == 0)
                grow = !grow;
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                queue_request($urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7,
                              rand_value(), 5'($urandom_range(0, 31)));
            end
            else
            begin
                if (roll < 12)
                    queue_request(REQ_DUMP, rand_value(), 5'($urandom_range(0, 31)));
                else if (roll < (grow ? 75 : 40))
                begin
                    case ($urandom_range(0, 2))
                        0: queue_request(REQ_INS_HEAD, rand_value(),
                                         5'($urandom_range(0, 31)));
                        1: queue_request(REQ_INS_TAIL, rand_value(),
                                         5'($urandom_range(0, 31)));
                        default: queue_request(REQ_INS_AT, rand_value(), rand_position());
                    endcase
                end
                else
                    queue_request($urandom_range(0, 1) ? REQ_REM_HEAD : REQ_REM_TAIL,
                                  rand_value(), 5'($urandom_range(0, 31)));
                n_items++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_req_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
